FILE: rtl/core/bcel_pkg.sv
`default_nettype none
package bcel_pkg;

    localparam int MAX_ITEMS      = 65536;
    localparam int LOG_TABLE_BITS = 8;
    localparam int TAB_SIZE       = 1 << LOG_TABLE_BITS;
    localparam int CNT_W          = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W          = 40;
    localparam int LN_W           = 20;
    localparam int PROD_W         = 36;
    localparam int ITER_W         = $clog2(SUM_W);
    localparam int LOSS_W         = 24;

    localparam logic [15:0]       LN2_Q16  = 16'd45426;
    localparam logic [15:0]       ONE_Q15  = 16'd32768;
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_ITEMS);

    typedef logic [15:0] log_tab_t [TAB_SIZE];

    // controller to datapath
    typedef struct packed {
        logic load;
        logic ln_en;
        logic mul1_en;
        logic mul2_en;
        logic acc_en;
        logic div_start;
        logic div_step;
        logic out_load;
    } bcel_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;
        logic div_last;
    } bcel_stat_t;

    // truncated log2 of a Q1.30 value in [1,2), Q.16, by repeated squaring
    function automatic logic [15:0] frac_log2(input logic [63:0] v_in);
        logic [63:0] v;
        logic [15:0] r;
        v = v_in;
        r = '0;
        for (int k = 0; k < 16; k++) begin
            v = (v * v) >> 30;
            r = {r[14:0], 1'b0};
            if (v >= (64'd2 << 30)) begin
                r[0] = 1'b1;
                v = v >> 1;
            end
        end
        return r;
    endfunction

    function automatic log_tab_t build_tab();
        log_tab_t t;
        for (int i = 0; i < TAB_SIZE; i++) begin
            t[i] = frac_log2(64'(TAB_SIZE + i) << (30 - LOG_TABLE_BITS));
        end
        return t;
    endfunction

    localparam log_tab_t LOG2_TAB = build_tab();

endpackage
`default_nettype wire

FILE: rtl/core/bcel_dp.sv
`default_nettype none
module bcel_dp
    import bcel_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire bcel_cmd_t          cmd,
    output bcel_stat_t              stat,
    input  wire logic signed [17:0] prediction,
    input  wire logic [15:0]        label,
    input  wire logic               last_item,
    output logic [LOSS_W-1:0]       loss,
    output logic                    status
);

    // magnitude of log2(x) in Q.16 for x in Q1.15, x clamped to 1 LSB
    function automatic logic [LN_W-1:0] nl2_f(input logic [15:0] xin);
        logic [15:0] x;
        logic [3:0]  msb;
        logic [15:0] xn;
        logic [LOG_TABLE_BITS-1:0] m;
        x = (xin == 16'd0) ? 16'd1 : xin;
        msb = '0;
        for (int k = 0; k < 16; k++) begin
            if (x[k]) msb = 4'(k);
        end
        xn = x << (4'd15 - msb);
        m = xn[14 -: LOG_TABLE_BITS];
        return (LN_W'(4'd15 - msb) << 16) - LN_W'(LOG2_TAB[m]);
    endfunction

    logic [15:0]       pa_reg, pb_reg, ya_reg, yb_reg;
    logic              last_reg, skip_reg, err_in_reg;
    logic [LN_W-1:0]   nla_reg, nlb_reg, lna_reg, lnb_reg;
    logic [PROD_W-1:0] pra_reg, prb_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              err_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W:0]    rem_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [LOSS_W-1:0] loss_reg;
    logic              status_reg;

    logic [15:0]       p_clamp, y_clamp;
    logic              p_bad;
    logic [PROD_W:0]   mag;
    logic [21:0]       term;
    logic [SUM_W:0]    sum_wide;
    logic [CNT_W+1:0]  rem_sh, rem_sub;

    // input clamping
    always_comb begin
        p_bad = (prediction < 18'sd0) || (prediction > 18'sd32768);
        if (prediction < 18'sd0) begin
            p_clamp = '0;
        end else if (prediction > 18'sd32768) begin
            p_clamp = ONE_Q15;
        end else begin
            p_clamp = prediction[15:0];
        end
        y_clamp = (label > ONE_Q15) ? ONE_Q15 : label;
    end

    // term and divider step
    always_comb begin
        mag      = (PROD_W+1)'(pra_reg) + (PROD_W+1)'(prb_reg);
        term     = 22'((mag + (PROD_W+1)'(32767)) >> 15);
        sum_wide = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(term);
        rem_sh   = (CNT_W+2)'({rem_reg, quo_reg[SUM_W-1]});
        rem_sub  = rem_sh - (CNT_W+2)'(div_reg);
    end

    // payload pipeline
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pa_reg     <= p_clamp;
            pb_reg     <= ONE_Q15 - p_clamp;
            ya_reg     <= y_clamp;
            yb_reg     <= ONE_Q15 - y_clamp;
            last_reg   <= last_item;
            skip_reg   <= (cnt_reg == CNT_FULL);
            err_in_reg <= p_bad;
        end
        if (cmd.ln_en) begin
            nla_reg <= nl2_f(pa_reg);
            nlb_reg <= nl2_f(pb_reg);
        end
        if (cmd.mul1_en) begin
            lna_reg <= LN_W'(((PROD_W'(nla_reg) * PROD_W'(LN2_Q16)) + PROD_W'(65535)) >> 16);
            lnb_reg <= LN_W'(((PROD_W'(nlb_reg) * PROD_W'(LN2_Q16)) + PROD_W'(65535)) >> 16);
        end
        if (cmd.mul2_en) begin
            pra_reg <= PROD_W'(ya_reg) * PROD_W'(lna_reg);
            prb_reg <= PROD_W'(yb_reg) * PROD_W'(lnb_reg);
        end
        if (cmd.div_start) begin
            quo_reg  <= sum_reg;
            div_reg  <= cnt_reg;
            rem_reg  <= '0;
            iter_reg <= '0;
            status_reg <= err_reg;
        end else if (cmd.div_step) begin
            iter_reg <= iter_reg + ITER_W'(1);
            if (!rem_sub[CNT_W+1]) begin
                rem_reg <= rem_sub[CNT_W:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[CNT_W:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load) begin
            loss_reg <= (quo_reg > SUM_W'({LOSS_W{1'b1}})) ? {LOSS_W{1'b1}}
                                                           : quo_reg[LOSS_W-1:0];
        end
    end

    // accumulator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            cnt_reg <= '0;
            err_reg <= 1'b0;
        end else if (cmd.div_start) begin
            sum_reg <= '0;
            cnt_reg <= '0;
            err_reg <= 1'b0;
        end else if (cmd.acc_en && !skip_reg) begin
            sum_reg <= sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
            cnt_reg <= cnt_reg + CNT_W'(1);
            err_reg <= err_reg | err_in_reg;
        end
    end

    assign stat.last     = last_reg;
    assign stat.div_last = (iter_reg == ITER_W'(SUM_W - 1));
    assign loss          = loss_reg;
    assign status        = status_reg;

endmodule
`default_nettype wire

FILE: rtl/core/bcel_ctrl.sv
`default_nettype none
module bcel_ctrl
    import bcel_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire bcel_stat_t stat,
    output bcel_cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LN, ST_MUL1, ST_MUL2, ST_ACC,
        ST_DSTART, ST_DIV, ST_FIN, ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, m_tvalid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid && s_tready_reg) state_next = ST_LN;
            ST_LN:     state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_ACC;
            ST_ACC:    state_next = stat.last ? ST_DSTART : ST_IDLE;
            ST_DSTART: state_next = ST_DIV;
            ST_DIV:    if (stat.div_last) state_next = ST_FIN;
            ST_FIN:    state_next = ST_DONE;
            ST_DONE:   if (m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // state and registered handshake outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == ST_IDLE);
            m_tvalid_reg <= (state_next == ST_DONE);
        end
    end

    // datapath commands
    always_comb begin
        cmd           = '0;
        cmd.load      = s_tvalid && s_tready_reg;
        cmd.ln_en     = (state_reg == ST_LN);
        cmd.mul1_en   = (state_reg == ST_MUL1);
        cmd.mul2_en   = (state_reg == ST_MUL2);
        cmd.acc_en    = (state_reg == ST_ACC);
        cmd.div_start = (state_reg == ST_DSTART);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.out_load  = (state_reg == ST_FIN);
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

    // checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready_reg && m_tvalid_reg))
        else $error("input and output open together");
    a_ready_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready_reg) |=> !s_tready_reg)
        else $error("input still open after a transfer");
    a_result_only_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("result raised without a division");
    a_ready_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready_reg |-> state_reg == ST_IDLE)
        else $error("input open outside idle");

endmodule
`default_nettype wire

FILE: rtl/core/binary_cross_entropy_loss.sv
// Mean binary cross-entropy over a stream of (prediction, label) pairs in Q1.15.
// Each accepted transfer adds -(y*ln(p) + (1-y)*ln(1-p)) to a 40-bit saturating
// sum; the transfer with s_tlast set closes the vector and yields one result:
// the truncated mean in unsigned Q8.16 (saturated at 24 bits) with m_tuser set
// if any prediction fell outside 0..1. An item passes through load, log table
// lookup, ln2 scaling, label multiply and accumulate steps; a last item then
// goes on to the restoring divider, which retires one quotient bit per cycle over
// the 40-bit sum between a start and a finish step, before the result is offered.
// Items past 65536 in one vector are ignored.
`default_nettype none
module binary_cross_entropy_loss
    import bcel_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // prediction [17:0], label [33:18], zero pad
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // loss [23:0]
    output logic             m_tuser    // status [0]
);

    bcel_cmd_t  cmd;
    bcel_stat_t stat;

    bcel_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bcel_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .prediction (s_tdata[17:0]),
        .label      (s_tdata[33:18]),
        .last_item  (s_tlast),
        .loss       (m_tdata),
        .status     (m_tuser)
    );

endmodule
`default_nettype wire

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIMIT_CYCLES = 1500000;
    localparam int          ONE          = 32768;
    localparam int          TBITS        = 8;
    localparam int          MAXN         = 65536;
    localparam logic [39:0] SUM_TOP      = {40{1'b1}};
    localparam int          LOSS_TOP     = 24'hFFFFFF;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;

    typedef struct {
        logic [23:0] loss;
        logic        status;
    } loss_res_t;

    typedef struct {
        logic signed [17:0] pred;
        logic [15:0]        label;
        logic               last;
        bit                 typed;
        logic [23:0]        loss;
        logic               status;
    } stim_row_t;

    loss_res_t   loss_expected[$];
    logic [15:0] log2_frac [1 << TBITS];
    logic [39:0] bce_sum;
    int unsigned bce_cnt;
    bit          bce_err;
    int          errors;
    int          cycles;
    int          vectors_seen;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          cur_typed;
    logic [23:0] cur_loss;
    logic        cur_status;

    binary_cross_entropy_loss DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // log2(1+i/2^TBITS) in Q.16, truncated, by repeated squaring
    function automatic logic [15:0] log2_mant(input int unsigned idx);
        logic [63:0] v;
        logic [15:0] r;
        v = 64'(((1 << TBITS) + idx)) << (30 - TBITS);
        r = '0;
        for (int k = 0; k < 16; k++) begin
            v = (v * v) >> 30;
            r = r << 1;
            if (v >= (64'd1 << 31)) begin
                r[0] = 1'b1;
                v = v >> 1;
            end
        end
        return r;
    endfunction

    // magnitude of ln(x) in Q.16, x in Q1.15 clamped to 1 lsb
    function automatic logic [63:0] minus_ln(input int unsigned x);
        int unsigned lead;
        int unsigned mant;
        logic [63:0] mag2;
        lead = 0;
        if (x < 1) x = 1;
        for (int unsigned t = x; t > 1; t = t >> 1) lead++;
        if (lead >= TBITS) mant = (x >> (lead - TBITS)) & ((1 << TBITS) - 1);
        else mant = (x << (TBITS - lead)) & ((1 << TBITS) - 1);
        mag2 = 64'(15 - lead) * 64'd65536 - 64'(log2_frac[mant]);
        return (mag2 * 64'd45426 + 64'd65535) >> 16;
    endfunction

    // accumulate one accepted pair; on the last one queue the mean, or the typed row's result
    task automatic bce_accept(input logic [39:0] d, input logic last);
        int          p;
        int unsigned y;
        logic [63:0] mag;
        logic [63:0] term;
        logic [63:0] q;
        loss_res_t   r;
        p = int'($signed(d[17:0]));
        y = d[33:18];
        if (bce_cnt < MAXN) begin
            if (p < 0 || p > ONE) begin
                bce_err = 1'b1;
                p = (p < 0) ? 0 : ONE;
            end
            if (y > ONE) y = ONE;
            mag = 64'(y) * minus_ln(p) + 64'(ONE - y) * minus_ln(ONE - p);
            term = (mag + 64'd32767) >> 15;
            if (64'(bce_sum) + term > 64'(SUM_TOP)) bce_sum = SUM_TOP;
            else bce_sum = bce_sum + term[39:0];
            bce_cnt++;
        end
        if (last) begin
            q = 64'(bce_sum) / 64'(bce_cnt);
            if (q > LOSS_TOP) q = LOSS_TOP;
            r.loss   = cur_typed ? cur_loss : q[23:0];
            r.status = cur_typed ? cur_status : bce_err;
            loss_expected.push_back(r);
            bce_sum = '0;
            bce_cnt = 0;
            bce_err = 1'b0;
        end
    endtask

    // input and result monitors
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && s_tvalid && s_tready) bce_accept(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            vectors_seen++;
            if (loss_expected.size() == 0) begin
                $display("%0t: unexpected result loss=%0d status=%0d",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                if (m_tdata !== loss_expected[0].loss
                    || m_tuser !== loss_expected[0].status) begin
                    $display("%0t: expected loss=%0d status=%0d, actual loss=%0d status=%0d",
                             $time, loss_expected[0].loss, loss_expected[0].status,
                             m_tdata, m_tuser);
                    errors++;
                end
                void'(loss_expected.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (cycles > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver backpressure
    always @(negedge aclk) begin
        if (aresetn) m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // one input transfer, with random idle cycles ahead of it
    task automatic send_pair(input logic signed [17:0] pred, input logic [15:0] label,
                             input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, label, pred};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic signed [17:0] rand_pred();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8) return 18'sd0;
        if (sel < 16) return 18'sd32768;
        if (sel < 26) return 18'($urandom());
        return 18'($urandom_range(0, ONE));
    endfunction

    function automatic logic [15:0] rand_label();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 15) return 16'd0;
        if (sel < 30) return 16'd32768;
        if (sel < 38) return 16'($urandom());
        return 16'($urandom_range(0, ONE));
    endfunction

    task automatic random_vectors(input int n_items);
        int left;
        int len;
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                              : $urandom_range(1, 8);
            if (len > left) len = left;
            for (int i = 0; i < len; i++) send_pair(rand_pred(), rand_label(), i == len - 1);
            left -= len;
        end
    endtask

    stim_row_t directed[$];

    initial begin
        errors = 0; cycles = 0; vectors_seen = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        cur_typed = 1'b0; cur_loss = '0; cur_status = 1'b0;
        bce_sum = '0; bce_cnt = 0; bce_err = 1'b0;
        for (int i = 0; i < (1 << TBITS); i++) log2_frac[i] = log2_mant(i);
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0; m_tready = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // pred, label, last, typed, loss, status
        directed = '{
            '{18'sd32768,  16'd32768, 1'b1, 1'b1, 24'd0,      1'b0},
            '{18'sd0,      16'd0,     1'b1, 1'b1, 24'd0,      1'b0},
            '{18'sd0,      16'd32768, 1'b1, 1'b1, 24'd681390, 1'b0},
            '{18'sd32768,  16'd0,     1'b1, 1'b1, 24'd681390, 1'b0},
            '{-18'sd1,     16'd0,     1'b1, 1'b1, 24'd0,      1'b1},
            '{18'sd131071, 16'd32768, 1'b1, 1'b1, 24'd0,      1'b1},
            '{-18'sd131072,16'd32768, 1'b1, 1'b1, 24'd681390, 1'b1},
            '{18'sd32769,  16'd0,     1'b1, 1'b1, 24'd681390, 1'b1},
            '{18'sd16384,  16'd16384, 1'b1, 1'b0, 24'd0,      1'b0},
            '{18'sd1,      16'd65535, 1'b1, 1'b0, 24'd0,      1'b0},
            '{18'sd32767,  16'd32769, 1'b1, 1'b0, 24'd0,      1'b0},
            '{18'sd100,    16'd1,     1'b0, 1'b0, 24'd0,      1'b0},
            '{-18'sd5,     16'd20000, 1'b0, 1'b0, 24'd0,      1'b0},
            '{18'sd30000,  16'd32767, 1'b0, 1'b0, 24'd0,      1'b0},
            '{18'sd255,    16'd300,   1'b1, 1'b0, 24'd0,      1'b0},
            '{18'sd12345,  16'd0,     1'b0, 1'b0, 24'd0,      1'b0},
            '{18'sd7,      16'd32768, 1'b1, 1'b0, 24'd0,      1'b0}
        };
        foreach (directed[i]) begin
            cur_typed  <= directed[i].typed;
            cur_loss   <= directed[i].loss;
            cur_status <= directed[i].status;
            send_pair(directed[i].pred, directed[i].label, directed[i].last);
        end
        s_tvalid <= 1'b0;
        cur_typed <= 1'b0;

        // random phases with different idle patterns
        send_idle_pct = 0;  recv_stall_pct = 0;  random_vectors(180);
        send_idle_pct = 87; recv_stall_pct = 0;  random_vectors(180);
        send_idle_pct = 0;  recv_stall_pct = 87; random_vectors(180);
        send_idle_pct = 21; recv_stall_pct = 21; random_vectors(180);
        s_tvalid <= 1'b0;

        // drain
        recv_stall_pct = 0;
        while (loss_expected.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("covered %0d loss vectors: extremes, out-of-range and over-one inputs,",
                 vectors_seen);
        $display("under four idle patterns on sender and receiver");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
